[rtl/core/button_frame_event_queue_macros.svh]
// Assertion macros used by the checker of the button frame event queue.
// Depends on a clk and an arst_n signal in the scope where a macro is used.
`ifndef BUTTON_FRAME_EVENT_QUEUE_MACROS_SVH
`define BUTTON_FRAME_EVENT_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFEQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("button frame event queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFEQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("button frame event queue check failed");

`endif

[rtl/core/bfeq_pkg.sv]
// Package of the button frame event queue: field widths, codes and types.
// Used by the interfaces, top level, front end, back end and checker; depends on nothing.
package bfeq_pkg;

	// Field widths of the item, result and configuration port.
	localparam int OP_W        = 2;
	localparam int ID_W        = 29;
	localparam int LEN_W       = 4;
	localparam int MASK_W      = 8;
	localparam int TIME_W      = 32;
	localparam int BTN_W       = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 1;

	// Operation codes carried by an input item.
	localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
	localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
	localparam logic [OP_W-1:0] OP_POP   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_ID      = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_LIMIT = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [ID_W-1:0]   WHEEL_ID_RESET      = 29'd820;
	localparam logic [TIME_W-1:0] SILENCE_LIMIT_RESET = 32'd200;

	// Shortest frame that is taken.
	localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 4'd8;

	// Command kinds passed from the front end to the back end.
	localparam logic [1:0] CMD_FRAME  = 2'd0;
	localparam logic [1:0] CMD_CHECK  = 2'd1;
	localparam logic [1:0] CMD_POP    = 2'd2;
	localparam logic [1:0] CMD_STATUS = 2'd3;

	// One classified command.
	typedef struct packed {
		logic [1:0]        kind;
		logic [MASK_W-1:0] buttons_in;
		logic [TIME_W-1:0] now_ms;
	} cmd_t;

	// One stored button event.
	typedef struct packed {
		logic [BTN_W-1:0]  button;
		logic              pressed;
		logic [TIME_W-1:0] time_ms;
	} event_t;

	// One result item.
	typedef struct packed {
		logic              event_valid;
		logic [BTN_W-1:0]  event_button;
		logic              event_pressed;
		logic [TIME_W-1:0] event_time_ms;
		logic [MASK_W-1:0] buttons_now;
		logic              timed_out;
	} result_t;

endpackage

[rtl/core/bfeq_item_if.sv]
// Input channel of the button frame event queue: valid, ready and item fields.
// Depends on bfeq_pkg for the field widths.
interface bfeq_item_if;

	logic                         valid;
	logic                         ready;
	logic [bfeq_pkg::OP_W-1:0]    operation;
	logic [bfeq_pkg::ID_W-1:0]    frame_id;
	logic [bfeq_pkg::LEN_W-1:0]   frame_len;
	logic [bfeq_pkg::MASK_W-1:0]  buttons_in;
	logic [bfeq_pkg::TIME_W-1:0]  now_ms;

	modport source (
		output valid, operation, frame_id, frame_len, buttons_in, now_ms,
		input  ready
	);

	modport sink (
		input  valid, operation, frame_id, frame_len, buttons_in, now_ms,
		output ready
	);

endinterface

[rtl/core/bfeq_result_if.sv]
// Output channel of the button frame event queue: valid, ready and result fields.
// Depends on bfeq_pkg for the field widths.
interface bfeq_result_if;

	logic                         valid;
	logic                         ready;
	logic                         event_valid;
	logic [bfeq_pkg::BTN_W-1:0]   event_button;
	logic                         event_pressed;
	logic [bfeq_pkg::TIME_W-1:0]  event_time_ms;
	logic [bfeq_pkg::MASK_W-1:0]  buttons_now;
	logic                         timed_out;

	modport source (
		output valid, event_valid, event_button, event_pressed, event_time_ms,
		       buttons_now, timed_out,
		input  ready
	);

	modport sink (
		input  valid, event_valid, event_button, event_pressed, event_time_ms,
		       buttons_now, timed_out,
		output ready
	);

endinterface

[rtl/core/button_frame_event_queue.sv]
// Button frame event queue: top level with the configuration registers.
// Depends on bfeq_pkg, bfeq_item_if, bfeq_result_if, bfeq_front and bfeq_back.
//
// Frames from the wheel, silence checks and event pops enter on the item
// channel; each item gives exactly one result item, in order. The front end
// takes an item into a two-entry command queue, so input is accepted while
// the back end works, until that queue is full. In the back end a kept frame
// walks the button bits one per cycle, the last waiting for a free result
// slot, through the single write port of the event ring; a pop goes through
// the registered ring read, and a check or any other item is answered from
// idle. The ring holds QUEUE_SLOTS - 1 events; an event that finds it full is
// dropped. Configuration must be written while the block is idle; unenforced.
module button_frame_event_queue #(
	parameter int QUEUE_SLOTS  = 16,
	parameter int BUTTON_COUNT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	bfeq_item_if.sink                          item,
	bfeq_result_if.source                      result,
	input  logic                               cfg_write,
	input  logic [bfeq_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bfeq_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [bfeq_pkg::ID_W-1:0]   wheel_id_q;
	logic [bfeq_pkg::TIME_W-1:0] silence_limit_q;
	logic                        cmd_valid;
	logic                        cmd_ready;
	bfeq_pkg::cmd_t              cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_id_q      <= bfeq_pkg::WHEEL_ID_RESET;
			silence_limit_q <= bfeq_pkg::SILENCE_LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				bfeq_pkg::REG_WHEEL_ID:      wheel_id_q <= cfg_data[bfeq_pkg::ID_W-1:0];
				bfeq_pkg::REG_SILENCE_LIMIT: silence_limit_q <= cfg_data[bfeq_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end: accept and classify.
	bfeq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.wheel_id  (wheel_id_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	// Back end: carry out commands and produce results.
	bfeq_back #(
		.QUEUE_SLOTS  (QUEUE_SLOTS),
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_ready     (cmd_ready),
		.silence_limit (silence_limit_q),
		.result        (result)
	);

endmodule

[rtl/core/bfeq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the event ring of the button frame event queue.
module bfeq_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/bfeq_front.sv]
// Front end of the button frame event queue: accepts items, classifies them
// and holds them in a two-entry command queue. Depends on bfeq_pkg, bfeq_item_if.
module bfeq_front (
	input  logic                        clk,
	input  logic                        arst_n,
	bfeq_item_if.sink                   item,
	input  logic [bfeq_pkg::ID_W-1:0]   wheel_id,
	output logic                        cmd_valid,
	output bfeq_pkg::cmd_t              cmd,
	input  logic                        cmd_ready
);

	bfeq_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	bfeq_pkg::cmd_t cls;
	logic           push;
	logic           pop;

	// Classify the incoming item; a frame for another node or too short is
	// reduced to a plain status request.
	always_comb begin
		cls.buttons_in = item.buttons_in;
		cls.now_ms     = item.now_ms;
		case (item.operation)
			bfeq_pkg::OP_FRAME: begin
				if (item.frame_id == wheel_id && item.frame_len >= bfeq_pkg::MIN_FRAME_LEN) begin
					cls.kind = bfeq_pkg::CMD_FRAME;
				end else begin
					cls.kind = bfeq_pkg::CMD_STATUS;
				end
			end
			bfeq_pkg::OP_CHECK: cls.kind = bfeq_pkg::CMD_CHECK;
			bfeq_pkg::OP_POP:   cls.kind = bfeq_pkg::CMD_POP;
			default:            cls.kind = bfeq_pkg::CMD_STATUS;
		endcase
	end

	assign item.ready = (count_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign cmd_valid  = (count_q != 2'd0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = slot_q[rd_ptr_q];

	// Command queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// Command queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/core/bfeq_back.sv]
// Back end of the button frame event queue: walks the changed buttons into the
// event ring, pops events, tracks silence and registers the result item.
// Depends on bfeq_pkg, bfeq_result_if and bfeq_ram.
module bfeq_back #(
	parameter int QUEUE_SLOTS  = 16,
	parameter int BUTTON_COUNT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  bfeq_pkg::cmd_t                cmd,
	output logic                          cmd_ready,
	input  logic [bfeq_pkg::TIME_W-1:0]   silence_limit,
	bfeq_result_if.source                 result
);

	localparam int PTR_W = $clog2(QUEUE_SLOTS);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);
	localparam logic [bfeq_pkg::BTN_W-1:0] BTN_LAST = bfeq_pkg::BTN_W'(BUTTON_COUNT - 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0]                    state_q;
	logic [PTR_W-1:0]              wr_q;
	logic [PTR_W-1:0]              rd_q;
	logic [bfeq_pkg::MASK_W-1:0]   mask_q;
	logic [bfeq_pkg::TIME_W-1:0]   heard_q;
	logic                          silent_q;
	logic [bfeq_pkg::BTN_W-1:0]    idx_q;
	logic [bfeq_pkg::MASK_W-1:0]   bits_q;
	logic [bfeq_pkg::MASK_W-1:0]   changed_q;
	logic [bfeq_pkg::TIME_W-1:0]   now_q;
	logic                          res_valid_q;
	bfeq_pkg::result_t             res_q;

	logic                          slot_free;
	logic [PTR_W-1:0]              wr_next;
	logic [PTR_W-1:0]              rd_next;
	logic                          walk_last;
	logic                          walk_hit;
	logic                          ram_we;
	logic                          ram_re;
	bfeq_pkg::event_t              ram_wdata;
	bfeq_pkg::event_t              ram_rdata;
	logic                          emit;
	bfeq_pkg::result_t             res_d;
	logic                          take;

	// Event ring storage.
	bfeq_ram #(
		.WIDTH($bits(bfeq_pkg::event_t)),
		.DEPTH(QUEUE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	assign slot_free = !res_valid_q || result.ready;
	assign cmd_ready = (state_q == ST_IDLE) && slot_free;
	assign take      = cmd_valid && cmd_ready;
	assign wr_next   = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
	assign rd_next   = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
	assign walk_last = (idx_q == BTN_LAST);
	assign walk_hit  = changed_q[idx_q] && (wr_next != rd_q);

	// Event built by the current walk step.
	always_comb begin
		ram_wdata.button  = idx_q;
		ram_wdata.pressed = bits_q[idx_q];
		ram_wdata.time_ms = now_q;
	end

	// Sequencer decisions: RAM access and the result to register.
	always_comb begin
		logic [bfeq_pkg::TIME_W-1:0] elapsed;
		elapsed             = cmd.now_ms - heard_q;
		ram_we              = 1'b0;
		ram_re              = 1'b0;
		emit                = 1'b0;
		res_d.event_valid   = 1'b0;
		res_d.event_button  = '0;
		res_d.event_pressed = 1'b0;
		res_d.event_time_ms = '0;
		res_d.buttons_now   = mask_q;
		res_d.timed_out     = silent_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (cmd.kind)
						bfeq_pkg::CMD_CHECK: begin
							emit = 1'b1;
							res_d.timed_out = (heard_q == '0) || (elapsed > silence_limit);
						end
						bfeq_pkg::CMD_POP: begin
							if (rd_q != wr_q) begin
								ram_re = 1'b1;
							end else begin
								emit = 1'b1;
							end
						end
						bfeq_pkg::CMD_STATUS: emit = 1'b1;
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				if (!walk_last || slot_free) begin
					ram_we = walk_hit;
				end
				if (walk_last && slot_free) begin
					emit = 1'b1;
					res_d.buttons_now = bits_q;
				end
			end
			ST_READ: begin
				if (slot_free) begin
					emit = 1'b1;
					res_d.event_valid   = 1'b1;
					res_d.event_button  = ram_rdata.button;
					res_d.event_pressed = ram_rdata.pressed;
					res_d.event_time_ms = ram_rdata.time_ms;
				end
			end
			default: ;
		endcase
	end

	// Result payload register and the captured command fields.
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
		if (take) begin
			bits_q    <= cmd.buttons_in;
			changed_q <= cmd.buttons_in ^ mask_q;
			now_q     <= cmd.now_ms;
		end
	end

	// Sequencer, ring pointers and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_q        <= '0;
			rd_q        <= '0;
			mask_q      <= '0;
			heard_q     <= '0;
			silent_q    <= 1'b1;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (ram_we) begin
				wr_q <= wr_next;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (cmd.kind)
							bfeq_pkg::CMD_FRAME: begin
								heard_q <= cmd.now_ms;
								idx_q   <= '0;
								state_q <= ST_WALK;
							end
							bfeq_pkg::CMD_CHECK: silent_q <= res_d.timed_out;
							bfeq_pkg::CMD_POP: begin
								if (rd_q != wr_q) begin
									rd_q    <= rd_next;
									state_q <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (!walk_last) begin
						idx_q <= idx_q + bfeq_pkg::BTN_W'(1);
					end else if (slot_free) begin
						mask_q  <= bits_q;
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result channel.
	assign result.valid         = res_valid_q;
	assign result.event_valid   = res_q.event_valid;
	assign result.event_button  = res_q.event_button;
	assign result.event_pressed = res_q.event_pressed;
	assign result.event_time_ms = res_q.event_time_ms;
	assign result.buttons_now   = res_q.buttons_now;
	assign result.timed_out     = res_q.timed_out;

endmodule

[rtl/core/bfeq_checker.sv]
// Port-level checks of the button frame event queue, bound to the top level.
// Depends on bfeq_pkg and button_frame_event_queue_macros.svh.
`include "button_frame_event_queue_macros.svh"

module bfeq_checker #(
	parameter int BUTTON_COUNT = 8
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              event_valid,
	input logic [bfeq_pkg::BTN_W-1:0]        event_button,
	input logic                              event_pressed,
	input logic [bfeq_pkg::TIME_W-1:0]       event_time_ms,
	input logic [bfeq_pkg::MASK_W-1:0]       buttons_now,
	input logic                              timed_out
);

	// A stalled result item stays valid and keeps its contents, event_pressed apart.
	`BFEQ_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(event_valid) && $stable(event_button) && $stable(event_time_ms) && $stable(buttons_now) && $stable(timed_out))

	// A result without an event carries zero event fields.
	`BFEQ_ASSERT_NOW(a_no_event_zero, out_valid && !event_valid, event_button == '0 && event_pressed == 1'b0 && event_time_ms == '0)

	// A popped event names an existing button.
	`BFEQ_ASSERT_NOW(a_button_range, out_valid && event_valid, 32'(event_button) < 32'(BUTTON_COUNT))

endmodule

bind button_frame_event_queue bfeq_checker #(
	.BUTTON_COUNT (BUTTON_COUNT)
) u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.event_valid   (result.event_valid),
	.event_button  (result.event_button),
	.event_pressed (result.event_pressed),
	.event_time_ms (result.event_time_ms),
	.buttons_now   (result.buttons_now),
	.timed_out     (result.timed_out)
);
